[rtl/pif_pkg.sv]
package pif_pkg;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned NUM_PAIRS  = 8;
  localparam int unsigned NUM_ELEMS  = 16;
  localparam int unsigned ELEM_W     = 32;
  // plane coefficient: sum or difference of two 32-bit elements
  localparam int unsigned COEF_W     = ELEM_W + 1;
  localparam int unsigned PAIR_W     = 64;
  localparam int unsigned ADDR_W     = 6;

  // register indexes touched by reset (identity matrix)
  localparam int unsigned REG_PAIR_0 = 0;
  localparam int unsigned REG_PAIR_2 = 2;
  localparam int unsigned REG_PAIR_5 = 5;
  localparam int unsigned REG_PAIR_7 = 7;

  // matrix column combined with column 3 for each plane
  localparam int unsigned PLANE_COL [NUM_PLANES] = '{0, 0, 2, 1, 1, 2};
  // 1: column 3 minus the other column, 0: plus
  localparam logic [NUM_PLANES-1:0] PLANE_NEG = 6'b110001;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic en2;  // product stage load
    logic en3;  // partial sum stage load
  } stage_en_t;

endpackage

[rtl/pif_dot.sv]
module pif_dot #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk_i,
  input  pif_pkg::stage_en_t            en_i,
  input  pif_pkg::coef_t                coef_i [4],
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] pz_i,
  output logic                          neg_o
);

  localparam int PW = pif_pkg::COEF_W + COORD_WIDTH;
  localparam int DW = pif_pkg::COEF_W + FRAC_BITS;
  localparam int SW = ((PW > DW) ? PW : DW) + 2;

  logic signed [PW-1:0] prod_q [3];
  logic signed [DW-1:0] dterm_q;
  logic signed [SW-1:0] sa_q, sb_q;
  logic signed [SW:0]   sum;

  // stage 2: one 33x32 product per axis, offset term is a shift
  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      prod_q[0] <= PW'(coef_i[0]) * PW'(px_i);
      prod_q[1] <= PW'(coef_i[1]) * PW'(py_i);
      prod_q[2] <= PW'(coef_i[2]) * PW'(pz_i);
      dterm_q   <= DW'(coef_i[3]) <<< FRAC_BITS;
    end
  end

  // stage 3: two partial sums
  always_ff @(posedge clk_i) begin
    if (en_i.en3) begin
      sa_q <= SW'(prod_q[0]) + SW'(prod_q[1]);
      sb_q <= SW'(prod_q[2]) + SW'(dterm_q);
    end
  end

  assign sum   = (SW+1)'(sa_q) + (SW+1)'(sb_q);
  assign neg_o = sum[SW];

endmodule

[rtl/point_in_frustum_test.sv]
// Point-in-frustum test. Six clip planes are formed from the 4x4 matrix held
// in eight 64-bit APB registers (pair k at byte address 8*k: element 2k in
// bits 31:0, element 2k+1 in bits 63:32, signed fixed point with FRAC_BITS
// fraction bits; reset loads the identity). Each point transfer on the slave
// stream is tested against all six planes with an exact dot product; the
// result transfer carries the outside mask (bit k set when the point lies
// strictly under plane k) and an inside flag. Throughput is one point per
// clock while results are taken; points are registered on capture, and the
// depth is set by the eighteen 33x32 multipliers, which get a stage of their
// own, followed by a partial-sum stage and the final-sum/output stage. Stalls
// on the master side back up through the stages; empty stages are filled
// while the output waits. Matrix writes take effect for points accepted from
// the cycle after the write on; write only while no point is in flight.
module point_in_frustum_test #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // point stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // point_x[31:0], point_y[63:32], point_z[95:64]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // inside_res[0], outside_mask[6:1], zero[7]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pif_pkg::ADDR_W-1:0] paddr,
  input  logic [pif_pkg::PAIR_W-1:0] pwdata,
  output logic [pif_pkg::PAIR_W-1:0] prdata,
  output logic        pready
);

  localparam int unsigned NP = pif_pkg::NUM_PLANES;

  logic [pif_pkg::PAIR_W-1:0] matrix_q [pif_pkg::NUM_PAIRS];
  logic [2:0]                 reg_idx;
  logic signed [pif_pkg::ELEM_W-1:0] elem [pif_pkg::NUM_ELEMS];
  pif_pkg::coef_t             coef_d [NP][4];
  pif_pkg::coef_t             coef_q [NP][4];

  logic signed [COORD_WIDTH-1:0] px_q, py_q, pz_q;
  logic                       v1_q, v2_q, v3_q, v4_q;
  logic                       en1, en4;
  pif_pkg::stage_en_t         en;
  logic [NP-1:0]              neg;
  logic [NP-1:0]              mask_q;

  // ---------------------------------------------------------------- registers
  assign reg_idx = paddr[pif_pkg::ADDR_W-1:3];
  assign pready  = 1'b1;
  assign prdata  = matrix_q[reg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < pif_pkg::NUM_PAIRS; k++) begin
        matrix_q[k] <= '0;
      end
      matrix_q[pif_pkg::REG_PAIR_0] <= pif_pkg::PAIR_W'(1) << FRAC_BITS;
      matrix_q[pif_pkg::REG_PAIR_2] <= pif_pkg::PAIR_W'(1) << (FRAC_BITS + 32);
      matrix_q[pif_pkg::REG_PAIR_5] <= pif_pkg::PAIR_W'(1) << FRAC_BITS;
      matrix_q[pif_pkg::REG_PAIR_7] <= pif_pkg::PAIR_W'(1) << (FRAC_BITS + 32);
    end else if (psel && penable && pwrite && pready) begin
      matrix_q[reg_idx] <= pwdata;
    end
  end

  // plane coefficients: column 3 plus or minus the plane's column, per row
  always_comb begin
    for (int p = 0; p < pif_pkg::NUM_PAIRS; p++) begin
      elem[2*p]   = matrix_q[p][31:0];
      elem[2*p+1] = matrix_q[p][63:32];
    end
    for (int k = 0; k < NP; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (pif_pkg::PLANE_NEG[k]) begin
          coef_d[k][j] = pif_pkg::COEF_W'(elem[4*j+3])
                       - pif_pkg::COEF_W'(elem[4*j+pif_pkg::PLANE_COL[k]]);
        end else begin
          coef_d[k][j] = pif_pkg::COEF_W'(elem[4*j+3])
                       + pif_pkg::COEF_W'(elem[4*j+pif_pkg::PLANE_COL[k]]);
        end
      end
    end
  end

  // coefficients are registered so the adder stays out of the multiplier path
  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  // ---------------------------------------------------------------- pipeline
  // stage n loads when it is empty or its contents move on
  assign en4           = !v4_q || m_axis_tready;
  assign en.en3        = !v3_q || en4;
  assign en.en2        = !v2_q || en.en3;
  assign en1           = !v1_q || en.en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1)    v1_q <= s_axis_tvalid;
      if (en.en2) v2_q <= v1_q;
      if (en.en3) v3_q <= v2_q;
      if (en4)    v4_q <= v3_q;
    end
  end

  // stage 1: point capture, only the low COORD_WIDTH bits take part
  always_ff @(posedge clk_i) begin
    if (en1) begin
      px_q <= s_axis_tdata[COORD_WIDTH-1:0];
      py_q <= s_axis_tdata[32+COORD_WIDTH-1:32];
      pz_q <= s_axis_tdata[64+COORD_WIDTH-1:64];
    end
  end

  // stages 2 and 3 live in the per-plane dot product units
  for (genvar k = 0; k < NP; k++) begin : g_plane
    pif_dot #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_dot (
      .clk_i (clk_i),
      .en_i  (en),
      .coef_i(coef_q[k]),
      .px_i  (px_q),
      .py_i  (py_q),
      .pz_i  (pz_q),
      .neg_o (neg[k])
    );
  end

  // stage 4: final sign per plane into the output register
  always_ff @(posedge clk_i) begin
    if (en4) begin
      mask_q <= neg;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {1'b0, mask_q, (mask_q == '0)};

endmodule

[rtl/pif_checker.sv]
module pif_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // inside flag agrees with the mask
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[6:1] == 6'd0)))
    else $error("inside flag disagrees with outside mask");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[7])
    else $error("pad bit set");

  // with no result waiting, the pipeline can always take a point
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("point refused with empty output");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind point_in_frustum_test pif_checker u_pif_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .pready       (pready)
);

[verif/tb_point_in_frustum_test.sv]
module tb_point_in_frustum_test;
  timeunit 1ns;
  timeprecision 1ps;

  // DUT geometry, kept in step with the instance parameters below
  localparam int COORD_W     = 32;
  localparam int FRAC_W      = 16;
  localparam int ADDR_W      = pif_pkg::ADDR_W;
  localparam int PAIR_W      = pif_pkg::PAIR_W;
  localparam int PAIR_BYTES  = 8;      // 64-bit registers sit on 8-byte strides
  localparam int IDLE_MAX    = 16;     // longest per-transfer gap on either side
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the pipe
  localparam int DRAIN       = 24;     // quiet cycles at the end, well over latency
  localparam int LIMIT       = 400_000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 170;

  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] ONE   = 32'h0001_0000;   // 1.0 in Q16.16
  localparam logic [31:0] ONE_P = 32'h0001_0001;   // just past +1.0
  localparam logic [31:0] ONE_N = 32'hffff_0000;   // -1.0
  localparam logic [31:0] ONE_M = 32'hfffe_ffff;   // just past -1.0

  // plane k = column 3 (+/-) column PLANE_SRC[k]; PLANE_SUB[k] picks minus
  localparam int unsigned PLANE_SRC [6] = '{0, 0, 2, 1, 1, 2};
  localparam logic [5:0]  PLANE_SUB     = 6'b110001;

  // matrix setups used by the directed table and the random phases
  typedef enum logic [2:0] {
    MAT_IDENTITY, MAT_ZERO, MAT_MAXPOS, MAT_MAXNEG, MAT_ALT, MAT_SMALL, MAT_RANDOM
  } mat_kind_e;

  typedef struct packed {
    logic       inside_res;
    logic [5:0] mask;
  } verdict_t;

  typedef struct packed {
    mat_kind_e   mat;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        known;    // verdict typed in below, else taken from the predictor
    logic        inside_res;
    logic [5:0]  mask;
  } point_row_t;

  // Directed points. Under the identity each plane reduces to +/-coord + 1.0,
  // so the on-plane and just-outside verdicts can be written down directly.
  localparam int NUM_ROWS = 23;
  localparam point_row_t POINT_ROWS [NUM_ROWS] = '{
    '{MAT_IDENTITY, 32'h0,  32'h0,  32'h0,  1'b1, 1'b1, 6'b000000},
    '{MAT_IDENTITY, ONE,    32'h0,  32'h0,  1'b1, 1'b1, 6'b000000},  // on plane 0
    '{MAT_IDENTITY, ONE_P,  32'h0,  32'h0,  1'b1, 1'b0, 6'b000001},
    '{MAT_IDENTITY, ONE_N,  32'h0,  32'h0,  1'b1, 1'b1, 6'b000000},  // on plane 1
    '{MAT_IDENTITY, ONE_M,  32'h0,  32'h0,  1'b1, 1'b0, 6'b000010},
    '{MAT_IDENTITY, 32'h0,  ONE_P,  32'h0,  1'b1, 1'b0, 6'b010000},
    '{MAT_IDENTITY, 32'h0,  ONE_M,  32'h0,  1'b1, 1'b0, 6'b001000},
    '{MAT_IDENTITY, 32'h0,  32'h0,  ONE_P,  1'b1, 1'b0, 6'b100000},
    '{MAT_IDENTITY, 32'h0,  32'h0,  ONE_M,  1'b1, 1'b0, 6'b000100},
    '{MAT_IDENTITY, C_MAX,  C_MAX,  C_MAX,  1'b1, 1'b0, 6'b110001},
    '{MAT_IDENTITY, C_MIN,  C_MIN,  C_MIN,  1'b1, 1'b0, 6'b001110},
    '{MAT_IDENTITY, C_MAX,  C_MIN,  32'h0,  1'b1, 1'b0, 6'b001001},
    // all-zero planes never put a point outside
    '{MAT_ZERO,     C_MAX,  C_MIN,  C_MAX,  1'b1, 1'b1, 6'b000000},
    '{MAT_ZERO,     32'h0,  32'h0,  32'h0,  1'b1, 1'b1, 6'b000000},
    // widest coefficients against widest coordinates
    '{MAT_MAXPOS,   C_MAX,  C_MAX,  C_MAX,  1'b0, 1'b0, 6'b000000},
    '{MAT_MAXPOS,   C_MIN,  C_MIN,  C_MIN,  1'b0, 1'b0, 6'b000000},
    '{MAT_MAXPOS,   C_MIN,  C_MAX,  32'h0,  1'b0, 1'b0, 6'b000000},
    '{MAT_MAXNEG,   C_MAX,  C_MAX,  C_MAX,  1'b0, 1'b0, 6'b000000},
    '{MAT_MAXNEG,   C_MIN,  C_MIN,  C_MIN,  1'b0, 1'b0, 6'b000000},
    '{MAT_ALT,      C_MAX,  C_MIN,  C_MAX,  1'b0, 1'b0, 6'b000000},
    '{MAT_ALT,      C_MIN,  C_MAX,  C_MIN,  1'b0, 1'b0, 6'b000000},
    '{MAT_ALT,      C_MAX,  C_MAX,  C_MAX,  1'b0, 1'b0, 6'b000000},
    // back to identity: (0.5, -0.5, 1.0) sits on plane 5
    '{MAT_IDENTITY, 32'h0000_8000, 32'hffff_8000, ONE, 1'b1, 1'b1, 6'b000000}
  };

  // ---------------------------------------------------------------------------
  // clock, reset and DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;    // point_x[31:0], point_y[63:32], point_z[95:64]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // inside_res[0], outside_mask[6:1], zero[7]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [PAIR_W-1:0] pwdata = '0;
  logic [PAIR_W-1:0] prdata;
  logic        pready;

  always #1 clk_i = ~clk_i;

  point_in_frustum_test #(
    .COORD_WIDTH (COORD_W),
    .FRAC_BITS   (FRAC_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // shared testbench state
  // ---------------------------------------------------------------------------
  logic [63:0] pair_q [8];     // our copy of the matrix registers
  verdict_t    verdict_q [$];  // verdicts owed by the DUT, oldest first
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;   // both sides run back to back while set
  bit          long_hold = 1'b0; // asks the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Predictor: rebuild the six planes from the matrix copy and take the exact
  // dot product at 128 bits. Coefficients are 33 bits, products 65 bits, so
  // nothing can wrap. The d term is scaled by 1.0 to line up with the point.
  // ---------------------------------------------------------------------------
  function automatic verdict_t classify_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] pz);
    logic signed [31:0]  el [16];
    logic signed [31:0]  base;
    logic signed [31:0]  oth;
    logic signed [32:0]  cf [4];
    logic signed [127:0] dot;
    verdict_t            v;
    for (int i = 0; i < 16; i++)
      el[i] = i[0] ? pair_q[i >> 1][63:32] : pair_q[i >> 1][31:0];
    v.mask = '0;
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 4; j++) begin
        base  = el[4*j + 3];
        oth   = el[4*j + PLANE_SRC[k]];
        cf[j] = PLANE_SUB[k] ? (base - oth) : (base + oth);
      end
      dot = cf[0] * px + cf[1] * py + cf[2] * pz + (cf[3] <<< FRAC_W);
      v.mask[k] = dot[127];   // strictly negative means outside
    end
    v.inside_res = (v.mask == '0);
    return v;
  endfunction

  // coordinate mix: small values around the unit cube, exact multiples of
  // 1.0 (on-plane ties), extremes, and full-range random for bit coverage
  function automatic logic [31:0] draw_coord();
    logic [31:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = $urandom_range(0, 6 * 65536) - 3 * 65536;
      4, 5:       c = ($urandom_range(0, 6) - 3) * 65536;
      6: begin
        case ($urandom_range(0, 2))
          0:       c = C_MAX;
          1:       c = C_MIN;
          default: c = '0;
        endcase
      end
      default:    c = $urandom;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // register port: writes with a setup and an access phase, read-back compared
  // with the written value, and the bus back to idle after each access
  // ---------------------------------------------------------------------------
  task automatic reg_write(input int unsigned idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * PAIR_BYTES);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // register takes the value here
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(input int unsigned idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * PAIR_BYTES);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);   // access phase: prdata is valid before this edge
    if (prdata !== val) begin
      $error("matrix_pair_%0d: expected %h, got %h", idx, val, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes a new matrix once every point in flight has come out.
  task automatic program_matrix(input mat_kind_e kind);
    logic [31:0] el [16];
    for (int i = 0; i < 16; i++) begin
      case (kind)
        MAT_IDENTITY: el[i] = (i % 5 == 0) ? ONE : '0;
        MAT_ZERO:     el[i] = '0;
        MAT_MAXPOS:   el[i] = C_MAX;
        MAT_MAXNEG:   el[i] = C_MIN;
        MAT_ALT:      el[i] = i[0] ? C_MIN : C_MAX;
        MAT_SMALL: begin
          el[i] = $urandom_range(0, 8 * 65536) - 4 * 65536;
          if ($urandom_range(0, 1) == 0) el[i][15:0] = '0;  // whole numbers -> ties
        end
        default:      el[i] = $urandom;
      endcase
    end
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    for (int p = 0; p < 8; p++) begin
      pair_q[p] = {el[2*p + 1], el[2*p]};
      reg_write(p, pair_q[p]);
      reg_check(p, pair_q[p]);
    end
  endtask

  // One point transfer; the verdict is queued at the edge that takes it.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic typed,
                            input verdict_t typed_v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.push_back(typed ? typed_v : classify_point(x, y, z));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus: reset, register reset values, directed table, random phases
  // ---------------------------------------------------------------------------
  initial begin
    mat_kind_e cur_mat;
    verdict_t  tv;
    mat_kind_e kind;

    for (int p = 0; p < 8; p++) pair_q[p] = '0;
    pair_q[pif_pkg::REG_PAIR_0] = 64'(ONE);
    pair_q[pif_pkg::REG_PAIR_2] = {ONE, 32'h0};
    pair_q[pif_pkg::REG_PAIR_5] = 64'(ONE);
    pair_q[pif_pkg::REG_PAIR_7] = {ONE, 32'h0};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers must come out of reset holding the identity
    for (int p = 0; p < 8; p++) reg_check(p, pair_q[p]);

    cur_mat = MAT_IDENTITY;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (POINT_ROWS[r].mat != cur_mat) begin
        cur_mat = POINT_ROWS[r].mat;
        program_matrix(cur_mat);
      end
      tv.inside_res = POINT_ROWS[r].inside_res;
      tv.mask       = POINT_ROWS[r].mask;
      send_point(POINT_ROWS[r].x, POINT_ROWS[r].y, POINT_ROWS[r].z,
                 POINT_ROWS[r].known, tv);
    end

    // random phases, each under a fresh matrix; small matrices dominate so
    // that inside verdicts and exact ties stay common
    tv = '0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       kind = MAT_IDENTITY;
        1:       kind = MAT_RANDOM;
        default: kind = MAT_SMALL;
      endcase
      program_matrix(kind);
      if (ph == 1 || ph == 4) long_hold = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_point(draw_coord(), draw_coord(), draw_coord(), 1'b0, tv);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_point_in_frustum_test passed");
    end else begin
      $display("tb_point_in_frustum_test failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, one long hold-off on request, and a
  // field-by-field compare against the oldest owed verdict
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    verdict_t    exp_v;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, IDLE_MAX);
      if (long_hold) begin
        stall     = HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (verdict_q.size() == 0) begin
        $error("result transfer with no point outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        exp_v = verdict_q.pop_front();
        if (m_axis_tdata[0] !== exp_v.inside_res) begin
          $error("inside_res: expected %b, got %b", exp_v.inside_res, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[6:1] !== exp_v.mask) begin
          $error("outside_mask: expected %b, got %b", exp_v.mask, m_axis_tdata[6:1]);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("tb_point_in_frustum_test failed");
      $finish;
    end
  end

endmodule

[point_in_frustum_test.f]
rtl/pif_pkg.sv
rtl/pif_dot.sv
rtl/point_in_frustum_test.sv
rtl/pif_checker.sv
verif/tb_point_in_frustum_test.sv
